FILE: hw/rtl/xml_entity_unescape_core_defines.svh
// assertion macros for the xml entity unescape core
// used by the port checker, no other dependencies
`ifndef XML_ENTITY_UNESCAPE_CORE_DEFINES_SVH
`define XML_ENTITY_UNESCAPE_CORE_DEFINES_SVH

// clocked check, off while reset is asserted
`define XEU_ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// clocked check, also active during reset
`define XEU_ASSERT_RST(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/xml_unesc_pkg.sv
// shared types and constants for the xml entity unescape core
// entity table and the batch record passed from front to back end
`timescale 1ns / 1ps
`default_nettype none

package xml_unesc_pkg;

	localparam int HOLD_DEPTH  = 5;
	localparam int MAX_OUT     = 6;
	localparam int ENT_COUNT   = 5;
	localparam int ENT_MAX_LEN = 6;
	localparam int CNT_W       = 3;
	localparam int BQ_DEPTH    = 2;
	localparam int BQ_PTR_W    = $clog2(BQ_DEPTH);
	localparam int BQ_CNT_W    = $clog2(BQ_DEPTH + 1);

	typedef logic [7:0] byte_t;

	localparam byte_t AMP_CHAR = 8'h26;

	localparam byte_t ENT_TEXT [ENT_COUNT][ENT_MAX_LEN] = '{
		'{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
		'{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
		'{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00}
	};

	localparam logic [CNT_W-1:0] ENT_LEN [ENT_COUNT] = '{3'd6, 3'd6, 3'd4, 3'd4, 3'd5};

	localparam byte_t ENT_VAL [ENT_COUNT] = '{8'h22, 8'h27, 8'h3C, 8'h3E, 8'h26};

	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [CNT_W-1:0]        cnt;
		logic                    last;
	} batch_t;

endpackage

`default_nettype wire

FILE: hw/rtl/xml_entity_unescape_core.sv
// Decodes the five predefined XML entities in a byte stream. A byte is taken every cycle
// while full is low; the back end sends the result bytes of a transaction one byte per cycle
// from its output register while that register is empty or popped, and full rises once two decoded
// batches wait in the queue between matcher and back end. Bytes that break a partial
// entity come out unchanged in arrival order; the last byte flushes anything held and
// its final result carries out_last.
// top level: instantiates xml_unesc_front, xml_unesc_bq and xml_unesc_back
// depends on xml_unesc_pkg
`timescale 1ns / 1ps
`default_nettype none

module xml_entity_unescape_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	output logic       full,
	input  wire  [7:0] in_byte,
	input  wire        in_last,
	output logic       empty,
	input  wire        pop,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import xml_unesc_pkg::*;

	logic   bq_push;
	logic   bq_full;
	logic   bq_pop;
	logic   bq_empty;
	batch_t bq_din;
	batch_t bq_dout;

	xml_unesc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_byte (in_byte),
		.in_last (in_last),
		.bq_push (bq_push),
		.bq_data (bq_din),
		.bq_full (bq_full)
	);

	xml_unesc_bq u_bq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (bq_push),
		.din    (bq_din),
		.full   (bq_full),
		.pop    (bq_pop),
		.dout   (bq_dout),
		.empty  (bq_empty)
	);

	xml_unesc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.bq_empty (bq_empty),
		.bq_data  (bq_dout),
		.bq_pop   (bq_pop),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.out_last (out_last)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/xml_unesc_front.sv
// front end: accepts bytes, matches entities, builds at most one output batch per transaction
// depends on xml_unesc_pkg
`timescale 1ns / 1ps
`default_nettype none

module xml_unesc_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	output logic                  full,
	input  wire  [7:0]            in_byte,
	input  wire                   in_last,
	output logic                  bq_push,
	output xml_unesc_pkg::batch_t bq_data,
	input  wire                   bq_full
);
	import xml_unesc_pkg::*;

	logic [HOLD_DEPTH-1:0][7:0] held_q;
	logic [CNT_W-1:0]           held_cnt_q;
	logic [CNT_W-1:0]           len_p1;
	logic                       accept;
	logic                       hit_full;
	logic                       hit_pre;
	logic                       hold_ext;
	logic                       is_amp;
	byte_t                      full_val;
	batch_t                     batch;

	assign full   = bq_full;
	assign accept = push && !bq_full;
	assign len_p1 = held_cnt_q + 3'd1;
	assign is_amp = (in_byte == AMP_CHAR);

	always_comb begin : match_logic
		logic ok;
		hit_full = 1'b0;
		hit_pre  = 1'b0;
		full_val = '0;
		for (int e = 0; e < ENT_COUNT; e++) begin
			ok = (len_p1 <= ENT_LEN[e]) && (in_byte == ENT_TEXT[e][held_cnt_q]);
			for (int i = 0; i < HOLD_DEPTH; i++) begin
				if ((CNT_W'(i) < held_cnt_q) && (held_q[i] != ENT_TEXT[e][i])) begin
					ok = 1'b0;
				end
			end
			if (ok) begin
				if (len_p1 == ENT_LEN[e]) begin
					hit_full = 1'b1;
					full_val = ENT_VAL[e];
				end else begin
					hit_pre = 1'b1;
				end
			end
		end
	end

	assign hold_ext = hit_pre && (held_cnt_q < CNT_W'(HOLD_DEPTH));

	always_comb begin
		for (int i = 0; i < HOLD_DEPTH; i++) begin
			batch.bytes[i] = (CNT_W'(i) < held_cnt_q) ? held_q[i] : in_byte;
		end
		batch.bytes[MAX_OUT-1] = in_byte;
		batch.last = in_last;
		if (hit_full) begin
			batch.bytes[0] = full_val;
			batch.cnt      = 3'd1;
		end else if (in_last) begin
			batch.cnt = len_p1;
		end else if (hold_ext) begin
			batch.cnt = '0;
		end else begin
			batch.cnt = is_amp ? held_cnt_q : len_p1;
		end
	end

	assign bq_data = batch;
	assign bq_push = accept && (batch.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= '0;
		end else if (accept) begin
			if (in_last || hit_full) begin
				held_cnt_q <= '0;
			end else if (hold_ext) begin
				held_cnt_q <= len_p1;
			end else if (is_amp) begin
				held_cnt_q <= 3'd1;
			end else begin
				held_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !in_last && !hit_full) begin
			if (hold_ext) begin
				held_q[held_cnt_q] <= in_byte;
			end else if (is_amp) begin
				held_q[0] <= in_byte;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/xml_unesc_bq.sv
// batch queue between front and back end, two entries
// depends on xml_unesc_pkg
`timescale 1ns / 1ps
`default_nettype none

module xml_unesc_bq (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  xml_unesc_pkg::batch_t din,
	output logic                  full,
	input  wire                   pop,
	output xml_unesc_pkg::batch_t dout,
	output logic                  empty
);
	import xml_unesc_pkg::*;

	batch_t                mem_q [BQ_DEPTH];
	logic [BQ_PTR_W-1:0]   wr_ptr_q;
	logic [BQ_PTR_W-1:0]   rd_ptr_q;
	logic [BQ_CNT_W-1:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (count_q == BQ_CNT_W'(BQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/xml_unesc_back.sv
// back end: sends the bytes of each batch one per cycle into the output register while it is empty or popped
// depends on xml_unesc_pkg
`timescale 1ns / 1ps
`default_nettype none

module xml_unesc_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   bq_empty,
	input  xml_unesc_pkg::batch_t bq_data,
	output logic                  bq_pop,
	output logic                  empty,
	input  wire                   pop,
	output logic [7:0]            out_byte,
	output logic                  out_last
);
	import xml_unesc_pkg::*;

	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic             load;
	logic             at_end;

	assign load     = !bq_empty && (!out_valid_q || pop);
	assign at_end   = (idx_q == (bq_data.cnt - 3'd1));
	assign bq_pop   = load && at_end;
	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_end ? '0 : idx_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= bq_data.bytes[idx_q];
			out_last_q <= bq_data.last && at_end;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/xml_unesc_checker.sv
// port checker for xml_entity_unescape_core, bound to the top level
// depends on xml_entity_unescape_core_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "xml_entity_unescape_core_defines.svh"

module xml_unesc_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       push,
	input wire       full,
	input wire       in_last,
	input wire       empty,
	input wire       pop,
	input wire [7:0] out_byte,
	input wire       out_last
);

	// stalled result holds
	`XEU_ASSERT_CLK(a_out_hold, !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_last))

	// a last-byte transaction always leaves a result waiting
	`XEU_ASSERT_CLK(a_last_gives_result, push && !full && in_last |=> ##1 !empty)

	// input back-pressure only while results wait
	`XEU_ASSERT_CLK(a_full_needs_output, full |-> !empty)

	// reset empties both sides
	`XEU_ASSERT_RST(a_reset_clear, !arst_n |=> empty && !full)

endmodule

bind xml_entity_unescape_core xml_unesc_checker u_chk (.*);

`default_nettype wire
